>>> src/mwv_pkg.sv
// Shared types, widths and iteration helpers for the moving-window volatility core.
// No dependencies; mwv_ctrl, mwv_dp and the top level import this package.
package mwv_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int LEN_W       = 9;
  localparam int LEN_MAX     = (1 << LEN_W) - 1;
  localparam int WL_RESET    = 20;
  localparam int VAR_W       = 47;
  localparam int SQR_W       = 2 * SAMPLE_BITS;
  localparam int SUM_W       = SAMPLE_BITS + LEN_W;
  localparam int SQ_W        = SQR_W + LEN_W;
  localparam int DIV_STEPS   = 4;
  localparam int DIV_W       = ((SQ_W + DIV_STEPS - 1) / DIV_STEPS) * DIV_STEPS;
  localparam int DIV_CYC     = DIV_W / DIV_STEPS;
  localparam int SQRT_STEPS  = 2;
  localparam int SQRT_CYC    = SAMPLE_BITS / SQRT_STEPS;
  localparam int CNT_MAX     = (DIV_CYC > SQRT_CYC) ? DIV_CYC : SQRT_CYC;
  localparam int CNT_W       = $clog2(CNT_MAX);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          restart;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] window_mean;
    logic [VAR_W-1:0]              window_variance;
    logic [SAMPLE_BITS-1:0]        volatility;
    logic                          window_full;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic rd;
    logic sq;
    logic upd;
    logic prep;
    logic div;
    logic mul;
    logic sub;
    logic sqrt;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic out_busy;
  } status_t;

  typedef struct packed {
    logic [DIV_W-1:0] quo;
    logic [LEN_W-1:0] rem;
  } div_st_t;

  typedef struct packed {
    logic [SQR_W-1:0]       rad;
    logic [SAMPLE_BITS-1:0] root;
    logic [SAMPLE_BITS:0]   rem;
  } sqrt_st_t;

  function automatic logic [SQR_W-1:0] sq_mag(input logic [SAMPLE_BITS-1:0] s);
    logic [SAMPLE_BITS-1:0] m;
    m = s[SAMPLE_BITS-1] ? (~s + SAMPLE_BITS'(1)) : s;
    return SQR_W'(m) * SQR_W'(m);
  endfunction

  // Restoring division, several quotient bits per call.
  function automatic div_st_t div_iter(input div_st_t s, input logic [LEN_W-1:0] d);
    div_st_t      st;
    logic [LEN_W:0] t;
    st = s;
    for (int i = 0; i < DIV_STEPS; i++) begin
      t = {st.rem, st.quo[DIV_W-1]};
      st.quo = {st.quo[DIV_W-2:0], 1'b0};
      if (t >= {1'b0, d}) begin
        t = t - {1'b0, d};
        st.quo[0] = 1'b1;
      end
      st.rem = t[LEN_W-1:0];
    end
    return st;
  endfunction

  // Digit-by-digit integer square root, several root bits per call.
  function automatic sqrt_st_t sqrt_iter(input sqrt_st_t s);
    sqrt_st_t                st;
    logic [SAMPLE_BITS+2:0]  r;
    logic [SAMPLE_BITS+2:0]  trial;
    st = s;
    for (int i = 0; i < SQRT_STEPS; i++) begin
      r     = {st.rem, st.rad[SQR_W-1:SQR_W-2]};
      trial = {1'b0, st.root, 2'b01};
      st.rad = {st.rad[SQR_W-3:0], 2'b00};
      if (r >= trial) begin
        r = r - trial;
        st.root = {st.root[SAMPLE_BITS-2:0], 1'b1};
      end else begin
        st.root = {st.root[SAMPLE_BITS-2:0], 1'b0};
      end
      st.rem = r[SAMPLE_BITS:0];
    end
    return st;
  endfunction

endpackage

>>> src/mwv_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mwv_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> src/mwv_ctrl.sv
// Sequencer for the volatility core: steps one word through ring update,
// division and square root (full window only) and output. Depends on mwv_pkg.
module mwv_ctrl
  import mwv_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_SQUARE, S_UPDATE, S_PREP,
    S_DIV, S_MUL, S_SUB, S_SQRT, S_DONE
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.load = accept;
        if (accept) state_nxt = S_READ;
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_SQUARE;
      end
      S_SQUARE: begin
        cmd.sq    = 1'b1;
        state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.upd   = 1'b1;
        state_nxt = S_PREP;
      end
      S_PREP: begin
        cmd.prep = 1'b1;
        if (status.full) begin
          state_nxt = S_DIV;
          cnt_nxt   = CNT_W'(DIV_CYC - 1);
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DIV: begin
        cmd.div = 1'b1;
        if (cnt_r == '0) state_nxt = S_MUL;
        else cnt_nxt = cnt_r - CNT_W'(1);
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_SUB;
      end
      S_SUB: begin
        cmd.sub   = 1'b1;
        state_nxt = S_SQRT;
        cnt_nxt   = CNT_W'(SQRT_CYC - 1);
      end
      S_SQRT: begin
        cmd.sqrt = 1'b1;
        if (cnt_r == '0) state_nxt = S_DONE;
        else cnt_nxt = cnt_r - CNT_W'(1);
      end
      S_DONE: begin
        if (!status.out_busy) begin
          cmd.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (cnt_r < CNT_W'(DIV_CYC)))
    else $error("divide counter out of range");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("second word taken while one is in progress");

  a_short_path: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PREP && !status.full) |=> (state_r == S_DONE))
    else $error("partial window did not go straight to output");
`endif

endmodule

>>> src/mwv_dp.sv
// Datapath of the volatility core: sample ring, running sums, shared-step
// divider pair, square root and output register. Depends on mwv_pkg, mwv_ram.
module mwv_dp
  import mwv_pkg::*;
#(
  parameter int MAX_WINDOW = 256
) (
  input  logic           clk,
  input  logic           rst_n,
  input  in_word_t       in_word,
  input  logic           cfg_we,
  input  logic [LEN_W-1:0] cfg_wdata,
  input  cmd_t           cmd,
  output status_t        status,
  output logic           out_valid,
  input  logic           out_stall,
  output out_word_t      out_word
);

  localparam int AW   = $clog2(MAX_WINDOW);
  localparam int MAXC = (MAX_WINDOW > LEN_MAX) ? LEN_MAX : MAX_WINDOW;
  localparam int CW   = ((AW + 1) > LEN_W) ? (AW + 1) : LEN_W;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAXC);

  logic [LEN_W-1:0]              wl_r;
  logic [LEN_W-1:0]              len_w;
  logic [SAMPLE_BITS-1:0]        sample_r;
  logic [AW-1:0]                 slot_r;
  logic [LEN_W-1:0]              fill_r;
  logic signed [SUM_W-1:0]       sum_r;
  logic [SQ_W-1:0]               sqsum_r;
  logic [SQR_W-1:0]              sq_r;
  logic [SQR_W-1:0]              old_sq_r;
  logic                          full_r;
  logic                          neg_r;
  div_st_t                       dsum_r, dsq_r, dsum_nxt, dsq_nxt;
  logic [SQR_W-1:0]              msq_r;
  logic [SAMPLE_BITS-1:0]        mean_r;
  logic [SQR_W-1:0]              var_r;
  sqrt_st_t                      sq_st_r, sq_st_nxt;
  logic                          out_valid_r;
  out_word_t                     out_r;
  logic [SAMPLE_BITS-1:0]        ram_rdata;
  logic                          evict;
  logic [LEN_W-1:0]              fill_inc;
  logic                          wrap;
  logic [SUM_W-1:0]              smag;
  logic [SAMPLE_BITS-1:0]        mmag;
  logic [SQR_W-1:0]              quo_sq;

  assign len_w = (wl_r == '0) ? LEN_W'(1) : ((wl_r > MAX_LEN) ? MAX_LEN : wl_r);

  assign evict    = (fill_r >= len_w);
  assign fill_inc = fill_r + LEN_W'(1);
  assign wrap     = ((CW'(slot_r) + CW'(1)) >= CW'(len_w));
  assign smag     = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign mmag     = dsum_r.quo[SAMPLE_BITS-1:0];
  assign quo_sq   = dsq_r.quo[SQR_W-1:0];

  assign dsum_nxt  = div_iter(dsum_r, len_w);
  assign dsq_nxt   = div_iter(dsq_r, len_w);
  assign sq_st_nxt = sqrt_iter(sq_st_r);

  mwv_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(MAX_WINDOW)
  ) u_ring (
    .clk  (clk),
    .we   (cmd.upd),
    .waddr(slot_r),
    .wdata(sample_r),
    .re   (cmd.rd),
    .raddr(slot_r),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r        <= LEN_W'(WL_RESET);
      slot_r      <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      sqsum_r     <= '0;
      full_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        wl_r    <= cfg_wdata;
        slot_r  <= '0;
        fill_r  <= '0;
        sum_r   <= '0;
        sqsum_r <= '0;
      end else if (cmd.load && in_word.restart) begin
        slot_r  <= '0;
        fill_r  <= '0;
        sum_r   <= '0;
        sqsum_r <= '0;
      end else if (cmd.upd) begin
        slot_r <= wrap ? '0 : slot_r + AW'(1);
        if (evict) begin
          sum_r   <= sum_r + SUM_W'(signed'(sample_r)) - SUM_W'(signed'(ram_rdata));
          sqsum_r <= sqsum_r + SQ_W'(sq_r) - SQ_W'(old_sq_r);
        end else begin
          sum_r   <= sum_r + SUM_W'(signed'(sample_r));
          sqsum_r <= sqsum_r + SQ_W'(sq_r);
          fill_r  <= fill_inc;
        end
        full_r <= evict || (fill_inc >= len_w);
      end
      if (cmd.publish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_r <= in_word.sample;
    end
    if (cmd.rd) begin
      sq_r <= sq_mag(sample_r);
    end
    if (cmd.sq) begin
      old_sq_r <= sq_mag(ram_rdata);
    end
    if (cmd.prep) begin
      dsum_r <= '{quo: DIV_W'(smag), rem: '0};
      dsq_r  <= '{quo: DIV_W'(sqsum_r), rem: '0};
      neg_r  <= sum_r[SUM_W-1];
    end else if (cmd.div) begin
      dsum_r <= dsum_nxt;
      dsq_r  <= dsq_nxt;
    end
    if (cmd.mul) begin
      msq_r  <= SQR_W'(mmag) * SQR_W'(mmag);
      mean_r <= neg_r ? (~mmag + SAMPLE_BITS'(1)) : mmag;
    end
    if (cmd.sub) begin
      var_r   <= (quo_sq > msq_r) ? (quo_sq - msq_r) : '0;
      sq_st_r <= '{rad: ((quo_sq > msq_r) ? (quo_sq - msq_r) : '0), root: '0, rem: '0};
    end else if (cmd.sqrt) begin
      sq_st_r <= sq_st_nxt;
    end
    if (cmd.publish) begin
      out_r.window_mean     <= full_r ? mean_r : '0;
      out_r.window_variance <= full_r ? var_r[VAR_W-1:0] : '0;
      out_r.volatility      <= full_r ? sq_st_r.root : '0;
      out_r.window_full     <= full_r;
    end
  end

  assign status.full     = full_r;
  assign status.out_busy = out_valid_r && out_stall;
  assign out_valid       = out_valid_r;
  assign out_word        = out_r;

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= len_w)
    else $error("fill count beyond window length");

  a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(slot_r) < CW'(len_w))
    else $error("write slot beyond window length");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |-> !(out_valid_r && out_stall))
    else $error("result word overwritten while stalled");

  a_full_match: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.upd && !cfg_we) |=> (full_r == (fill_r == len_w)))
    else $error("full flag disagrees with fill count");
`endif

endmodule

>>> src/moving_window_volatility_core.sv
// Moving-window volatility core: sliding mean, population variance and
// its square root over the last window_length samples.
// Input channel (in_valid/in_stall/in_word): one Q4.20 sample per word, with a
// restart bit that empties the window before the sample is taken.
// Output channel (out_valid/out_stall/out_word): exactly one result word per
// input word, in order: mean (Q4.20), variance (Q7.40), volatility (Q4.20) and
// window_full. Until the window holds window_length samples the word carries
// window_full = 0 and zero statistics.
// Config (cfg_we/cfg_wdata): writes window_length and empties the window; 0
// acts as 1, values above MAX_WINDOW act as MAX_WINDOW. Write only when idle.
// Flow: one word in flight at a time. A full-window word passes through ring read
// and sum update, the two 4-bit-per-cycle dividers, multiply and subtract, and the
// 2-bit-per-cycle square root before out_valid; a word on a partial window skips
// the dividers and the square root.
// The output register frees the input side: the next word is accepted while a
// result waits; if out_stall holds past the next result, in_stall stays high.
// Reset: window_length returns to 20 and the window is empty.
module moving_window_volatility_core
  import mwv_pkg::*;
#(
  parameter int MAX_WINDOW = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_word_t         in_word,
  output logic             out_valid,
  input  logic             out_stall,
  output out_word_t        out_word,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_wdata
);

  cmd_t    cmd;
  status_t status;

  mwv_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .status  (status),
    .cmd     (cmd)
  );

  mwv_dp #(
    .MAX_WINDOW(MAX_WINDOW)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .cmd      (cmd),
    .status   (status),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

endmodule
